>>> rtl/hfgi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfgi_pkg: shared types and constants for the FM gain init unit
// Item structs, command format between front and back, back FSM states and
// the saturating add used on gain sums.
// ----------------------------------------------------------------------------
package hfgi_pkg;

  localparam int NUM_VERTICES = 1024;
  localparam int GAIN_BITS    = 32;
  localparam int SUM_W        = GAIN_BITS + 1;
  localparam int ADDR_W       = $clog2(NUM_VERTICES);
  localparam int VTX_W        = 10;
  localparam int WGT_W        = 16;
  localparam int OUT_W        = 32;
  localparam int CNT_W        = 11;
  localparam int CQ_DEPTH     = 2;
  localparam int CQ_PTR_W     = $clog2(CQ_DEPTH);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_PIN   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PIN,
    OP_READ
  } cmd_op_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_PIN,
    BK_FA_WR,
    BK_FB_RD,
    BK_FB_WR
  } back_state_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [VTX_W-1:0] vertex;
    logic             side;
    logic [WGT_W-1:0] edge_weight;
    logic             edge_cut;
    logic             last_pin;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] free_gain;
    logic [OUT_W-1:0] internal_weight;
    logic             on_boundary;
    logic [CNT_W-1:0] boundary_count;
  } out_item_t;

  // one classified item; fa/fb are the free-gain targets of a closing edge
  typedef struct packed {
    cmd_op_t          op;
    logic [VTX_W-1:0] vertex;
    logic             in_range;
    logic [WGT_W-1:0] weight;
    logic             cut;
    logic             fa_en;
    logic [VTX_W-1:0] fa_v;
    logic             fb_en;
    logic [VTX_W-1:0] fb_v;
  } cmd_t;

  function automatic logic [GAIN_BITS-1:0] sat_add(input logic [GAIN_BITS-1:0] a,
                                                   input logic [WGT_W-1:0] w);
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + SUM_W'(w);
    return s[GAIN_BITS] ? {GAIN_BITS{1'b1}} : s[GAIN_BITS-1:0];
  endfunction

  function automatic logic in_range(input logic [VTX_W-1:0] v);
    return 32'(v) < NUM_VERTICES;
  endfunction

endpackage
`default_nettype wire

>>> rtl/hfgi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfgi_front: input side of the gain init unit
// Accepts items, drops unused function codes, tracks the per-side pin counts
// of the current hyperedge and resolves the free-gain targets at its last pin.
// ----------------------------------------------------------------------------
module hfgi_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire hfgi_pkg::in_item_t in_data,
  input  wire logic              q_full,
  input  wire logic              clearing,
  output logic                   q_push,
  output hfgi_pkg::cmd_t         q_cmd
);

  logic [1:0]                 cnt0_r, cnt0_nxt, cnt1_r, cnt1_nxt;
  logic [hfgi_pkg::VTX_W-1:0] vtx0_r, vtx0_nxt, vtx1_r, vtx1_nxt;
  logic [1:0]                 pc0, pc1;
  logic [hfgi_pkg::VTX_W-1:0] pv0, pv1;
  logic                       acc;

  assign in_full = q_full | clearing;
  assign acc     = in_push & ~in_full;

  always_comb begin
    // counts as they stand after this pin
    pc0 = cnt0_r;
    pc1 = cnt1_r;
    pv0 = vtx0_r;
    pv1 = vtx1_r;
    if (!in_data.side) begin
      if (cnt0_r == 2'd0) pv0 = in_data.vertex;
      if (cnt0_r != 2'd2) pc0 = cnt0_r + 2'd1;
    end else begin
      if (cnt1_r == 2'd0) pv1 = in_data.vertex;
      if (cnt1_r != 2'd2) pc1 = cnt1_r + 2'd1;
    end

    cnt0_nxt = cnt0_r;
    cnt1_nxt = cnt1_r;
    vtx0_nxt = vtx0_r;
    vtx1_nxt = vtx1_r;
    q_push   = 1'b0;

    q_cmd.op       = hfgi_pkg::OP_PIN;
    q_cmd.vertex   = in_data.vertex;
    q_cmd.in_range = hfgi_pkg::in_range(in_data.vertex);
    q_cmd.weight   = in_data.edge_weight;
    q_cmd.cut      = in_data.edge_cut;
    q_cmd.fa_en    = in_data.last_pin && in_data.edge_cut && pc0 == 2'd1 &&
                     hfgi_pkg::in_range(pv0);
    q_cmd.fa_v     = pv0;
    q_cmd.fb_en    = in_data.last_pin && in_data.edge_cut && pc1 == 2'd1 &&
                     hfgi_pkg::in_range(pv1);
    q_cmd.fb_v     = pv1;

    case (in_data.func)
      hfgi_pkg::FUNC_CLEAR: begin
        q_cmd.op = hfgi_pkg::OP_CLEAR;
        q_push   = acc;
        if (acc) begin
          cnt0_nxt = '0;
          cnt1_nxt = '0;
          vtx0_nxt = '0;
          vtx1_nxt = '0;
        end
      end
      hfgi_pkg::FUNC_PIN: begin
        q_push = acc;
        if (acc) begin
          if (in_data.last_pin) begin
            cnt0_nxt = '0;
            cnt1_nxt = '0;
            vtx0_nxt = '0;
            vtx1_nxt = '0;
          end else begin
            cnt0_nxt = pc0;
            cnt1_nxt = pc1;
            vtx0_nxt = pv0;
            vtx1_nxt = pv1;
          end
        end
      end
      hfgi_pkg::FUNC_READ: begin
        q_cmd.op = hfgi_pkg::OP_READ;
        q_push   = acc;
      end
      default: begin
        // unused code: taken and dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt0_r <= '0;
      cnt1_r <= '0;
      vtx0_r <= '0;
      vtx1_r <= '0;
    end else begin
      cnt0_r <= cnt0_nxt;
      cnt1_r <= cnt1_nxt;
      vtx0_r <= vtx0_nxt;
      vtx1_r <= vtx1_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/hfgi_cmdq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfgi_cmdq: command queue between front and back
// Small FIFO of classified commands, lets either side stall on its own.
// ----------------------------------------------------------------------------
module hfgi_cmdq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire hfgi_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output hfgi_pkg::cmd_t      head
);

  hfgi_pkg::cmd_t                slot_r [hfgi_pkg::CQ_DEPTH];
  logic [hfgi_pkg::CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [hfgi_pkg::CQ_PTR_W:0]   cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign full    = cnt_r == (hfgi_pkg::CQ_PTR_W + 1)'(hfgi_pkg::CQ_DEPTH);
  assign empty   = cnt_r == '0;
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == hfgi_pkg::CQ_PTR_W'(hfgi_pkg::CQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == hfgi_pkg::CQ_PTR_W'(hfgi_pkg::CQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

>>> rtl/hfgi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfgi_back: execution side of the gain init unit
// Owns the free-gain, internal-weight and boundary-mark memories, does the
// read-modify-write sequences, the clearing sweep and the result register.
// ----------------------------------------------------------------------------
module hfgi_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire hfgi_pkg::cmd_t    q_head,
  output logic                   q_pop,
  output logic                   clearing,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output hfgi_pkg::out_item_t    out_data
);

  hfgi_pkg::back_state_t          state_r, state_nxt;
  hfgi_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [hfgi_pkg::ADDR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [hfgi_pkg::CNT_W-1:0]     btotal_r, btotal_nxt;
  hfgi_pkg::out_item_t            out_r, out_nxt;
  logic                           out_vld_r, out_vld_nxt;
  logic                           out_take;

  logic [hfgi_pkg::GAIN_BITS-1:0] fg_mem [hfgi_pkg::NUM_VERTICES];
  logic [hfgi_pkg::GAIN_BITS-1:0] iw_mem [hfgi_pkg::NUM_VERTICES];
  logic                           bm_mem [hfgi_pkg::NUM_VERTICES];

  // iw and bm share one address; fg has separate read and write addresses
  logic                           vx_re;
  logic [hfgi_pkg::ADDR_W-1:0]    vx_addr;
  logic                           iw_we, bm_we, bm_wdata;
  logic [hfgi_pkg::GAIN_BITS-1:0] iw_wdata, iw_rdata_r;
  logic                           bm_rdata_r;
  logic                           fg_re, fg_we;
  logic [hfgi_pkg::ADDR_W-1:0]    fg_raddr, fg_waddr;
  logic [hfgi_pkg::GAIN_BITS-1:0] fg_wdata, fg_rdata_r;

  assign clearing  = state_r == hfgi_pkg::BK_CLEAR;
  assign out_empty = ~out_vld_r;
  assign out_data  = out_r;
  assign out_take  = out_pop & out_vld_r;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    clr_cnt_nxt = clr_cnt_r;
    btotal_nxt  = btotal_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r & ~out_take;
    q_pop       = 1'b0;
    vx_re       = 1'b0;
    vx_addr     = hfgi_pkg::ADDR_W'(cmd_r.vertex);
    iw_we       = 1'b0;
    iw_wdata    = hfgi_pkg::sat_add(iw_rdata_r, cmd_r.weight);
    bm_we       = 1'b0;
    bm_wdata    = 1'b1;
    fg_re       = 1'b0;
    fg_we       = 1'b0;
    fg_raddr    = hfgi_pkg::ADDR_W'(cmd_r.fa_v);
    fg_waddr    = hfgi_pkg::ADDR_W'(cmd_r.fa_v);
    fg_wdata    = hfgi_pkg::sat_add(fg_rdata_r, cmd_r.weight);

    case (state_r)
      hfgi_pkg::BK_CLEAR: begin
        vx_addr  = clr_cnt_r;
        fg_waddr = clr_cnt_r;
        iw_we    = 1'b1;
        bm_we    = 1'b1;
        fg_we    = 1'b1;
        iw_wdata = '0;
        bm_wdata = 1'b0;
        fg_wdata = '0;
        if (clr_cnt_r == hfgi_pkg::ADDR_W'(hfgi_pkg::NUM_VERTICES - 1)) begin
          state_nxt = hfgi_pkg::BK_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      hfgi_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_head;
          vx_addr  = hfgi_pkg::ADDR_W'(q_head.vertex);
          fg_raddr = hfgi_pkg::ADDR_W'(q_head.vertex);
          case (q_head.op)
            hfgi_pkg::OP_CLEAR: begin
              state_nxt   = hfgi_pkg::BK_CLEAR;
              clr_cnt_nxt = '0;
              btotal_nxt  = '0;
            end
            hfgi_pkg::OP_PIN: begin
              vx_re     = 1'b1;
              state_nxt = hfgi_pkg::BK_PIN;
            end
            hfgi_pkg::OP_READ: begin
              vx_re     = 1'b1;
              fg_re     = 1'b1;
              state_nxt = hfgi_pkg::BK_READ;
            end
            default: begin
            end
          endcase
        end
      end
      hfgi_pkg::BK_READ: begin
        // read data holds until the result register frees up
        if (!out_vld_r || out_take) begin
          out_nxt.free_gain       = cmd_r.in_range ? hfgi_pkg::OUT_W'(fg_rdata_r) : '0;
          out_nxt.internal_weight = cmd_r.in_range ? hfgi_pkg::OUT_W'(iw_rdata_r) : '0;
          out_nxt.on_boundary     = cmd_r.in_range & bm_rdata_r;
          out_nxt.boundary_count  = btotal_r;
          out_vld_nxt             = 1'b1;
          state_nxt               = hfgi_pkg::BK_IDLE;
        end
      end
      hfgi_pkg::BK_PIN: begin
        if (cmd_r.in_range) begin
          if (cmd_r.cut) begin
            if (!bm_rdata_r) begin
              bm_we = 1'b1;
              if (btotal_r != hfgi_pkg::COUNT_MAX) begin
                btotal_nxt = btotal_r + hfgi_pkg::CNT_W'(1);
              end
            end
          end else begin
            iw_we = 1'b1;
          end
        end
        if (cmd_r.fa_en) begin
          fg_re     = 1'b1;
          state_nxt = hfgi_pkg::BK_FA_WR;
        end else if (cmd_r.fb_en) begin
          fg_re     = 1'b1;
          fg_raddr  = hfgi_pkg::ADDR_W'(cmd_r.fb_v);
          state_nxt = hfgi_pkg::BK_FB_WR;
        end else begin
          state_nxt = hfgi_pkg::BK_IDLE;
        end
      end
      hfgi_pkg::BK_FA_WR: begin
        fg_we     = 1'b1;
        state_nxt = cmd_r.fb_en ? hfgi_pkg::BK_FB_RD : hfgi_pkg::BK_IDLE;
      end
      hfgi_pkg::BK_FB_RD: begin
        // separate read cycle: both sides may name the same vertex
        fg_re     = 1'b1;
        fg_raddr  = hfgi_pkg::ADDR_W'(cmd_r.fb_v);
        state_nxt = hfgi_pkg::BK_FB_WR;
      end
      hfgi_pkg::BK_FB_WR: begin
        fg_we     = 1'b1;
        fg_waddr  = hfgi_pkg::ADDR_W'(cmd_r.fb_v);
        state_nxt = hfgi_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = hfgi_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hfgi_pkg::BK_CLEAR;
      clr_cnt_r <= '0;
      btotal_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      btotal_r  <= btotal_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (iw_we) iw_mem[vx_addr] <= iw_wdata;
    if (bm_we) bm_mem[vx_addr] <= bm_wdata;
    if (vx_re) begin
      iw_rdata_r <= iw_mem[vx_addr];
      bm_rdata_r <= bm_mem[vx_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fg_we) fg_mem[fg_waddr] <= fg_wdata;
    if (fg_re) fg_rdata_r <= fg_mem[fg_raddr];
  end

endmodule
`default_nettype wire

>>> rtl/hypergraph_fm_gain_init_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hypergraph_fm_gain_init_unit: FM gain term builder for two-way partitioning
// Front classifies pins and tracks edge side counts, a two-entry command
// queue decouples it from the back end that updates the vertex memories.
// ----------------------------------------------------------------------------
// After reset, and after every clear item, the block runs a clearing sweep
// over all vertex memory addresses and holds in_full high throughout.
// Items otherwise queue up while the back end works; its cost per item is set
// by read-modify-write on the vertex memories: a pin is read, then written,
// with a free-gain read and write more for each side updated at an edge's
// last pin; a read waits for a free result register; an unused function code
// never reaches it. Results come out in item order; only reads produce one.
module hypergraph_fm_gain_init_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire hfgi_pkg::in_item_t  in_data,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output hfgi_pkg::out_item_t      out_data
);

  hfgi_pkg::cmd_t q_cmd, q_head;
  logic           q_push, q_full, q_pop, q_empty, clearing;

  hfgi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .q_full   (q_full),
    .clearing (clearing),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  hfgi_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  hfgi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_pop)
    else $error("command taken during clearing sweep");

  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_full)
    else $error("input open right after reset");

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the FM gain init unit
// Drives hyperedge pin, read, clear and spare-code beats through the input
// queue port, predicts every read result with a local copy of the vertex
// stores and edge side counts, and compares each popped result in order.
// Idle patterns on both sides change over three phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] FUNC_SPARE  = 2'd3;
  localparam int         STALL_LIMIT = 4000;
  localparam int         MAX_REPORTS = 10;

  typedef struct packed {
    hfgi_pkg::in_item_t item;
    logic [6:0]         snd_idle;
    logic [6:0]         rcv_idle;
    logic               drain;
  } send_entry_t;

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                in_push = 1'b0;
  hfgi_pkg::in_item_t  in_data = '0;
  logic                out_pop = 1'b0;
  logic                in_full;
  logic                out_empty;
  hfgi_pkg::out_item_t out_data;

  hypergraph_fm_gain_init_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stimulus queue and the reads still owed by the block
  send_entry_t         items_to_send [$];
  hfgi_pkg::out_item_t expected_reads [$];

  // local copy of the block state
  logic [hfgi_pkg::GAIN_BITS-1:0] gain_store [hfgi_pkg::NUM_VERTICES];
  logic [hfgi_pkg::GAIN_BITS-1:0] wgt_store  [hfgi_pkg::NUM_VERTICES];
  logic                           bnd_mark   [hfgi_pkg::NUM_VERTICES];
  logic [hfgi_pkg::CNT_W-1:0]     bnd_total;
  logic [1:0]                     side_cnt   [2];
  logic [hfgi_pkg::VTX_W-1:0]     side_vtx   [2];

  // build-time knobs
  logic [6:0]                 snd_pct;
  logic [6:0]                 rcv_pct;
  logic                       drain_next;
  logic [hfgi_pkg::VTX_W-1:0] hot_base;

  bit                  push_taken = 1'b0;
  bit                  pop_taken  = 1'b0;
  int                  stall_cycles = 0;
  int                  n_errors = 0;
  hfgi_pkg::out_item_t head_read;

  function automatic logic [hfgi_pkg::GAIN_BITS-1:0] add_sat(
      input logic [hfgi_pkg::GAIN_BITS-1:0] a,
      input logic [hfgi_pkg::WGT_W-1:0] w);
    logic [hfgi_pkg::GAIN_BITS-1:0] room;
    room = {hfgi_pkg::GAIN_BITS{1'b1}} - hfgi_pkg::GAIN_BITS'(w);
    return (a > room) ? {hfgi_pkg::GAIN_BITS{1'b1}} : a + hfgi_pkg::GAIN_BITS'(w);
  endfunction

  function automatic void reset_model();
    int i;
    for (i = 0; i < hfgi_pkg::NUM_VERTICES; i++) begin
      gain_store[i] = '0;
      wgt_store[i]  = '0;
      bnd_mark[i]   = 1'b0;
    end
    bnd_total = '0;
    for (i = 0; i < 2; i++) begin
      side_cnt[i] = '0;
      side_vtx[i] = '0;
    end
  endfunction

  // advance the local state by one accepted beat
  function automatic void update_gain_model(input hfgi_pkg::in_item_t it);
    hfgi_pkg::out_item_t r;
    int                  s;
    int                  j;
    s = int'(it.side);
    case (it.func)
      hfgi_pkg::FUNC_CLEAR: reset_model();
      hfgi_pkg::FUNC_READ: begin
        r.free_gain       = hfgi_pkg::OUT_W'(gain_store[it.vertex]);
        r.internal_weight = hfgi_pkg::OUT_W'(wgt_store[it.vertex]);
        r.on_boundary     = bnd_mark[it.vertex];
        r.boundary_count  = bnd_total;
        expected_reads.push_back(r);
      end
      hfgi_pkg::FUNC_PIN: begin
        if (side_cnt[s] == 2'd0) side_vtx[s] = it.vertex;
        if (side_cnt[s] != 2'd2) side_cnt[s]++;
        if (it.edge_cut) begin
          if (!bnd_mark[it.vertex]) begin
            bnd_mark[it.vertex] = 1'b1;
            if (bnd_total != hfgi_pkg::COUNT_MAX) bnd_total++;
          end
        end else begin
          wgt_store[it.vertex] = add_sat(wgt_store[it.vertex], it.edge_weight);
        end
        // closing pin: its own cut flag and weight decide the free gain
        if (it.last_pin) begin
          for (j = 0; j < 2; j++) begin
            if (it.edge_cut && side_cnt[j] == 2'd1)
              gain_store[side_vtx[j]] = add_sat(gain_store[side_vtx[j]], it.edge_weight);
            side_cnt[j] = '0;
            side_vtx[j] = '0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic hfgi_pkg::in_item_t pin_item(input logic [hfgi_pkg::VTX_W-1:0] v,
                                                  input logic s,
                                                  input logic [hfgi_pkg::WGT_W-1:0] w,
                                                  input logic c, input logic l);
    hfgi_pkg::in_item_t it;
    it.func        = hfgi_pkg::FUNC_PIN;
    it.vertex      = v;
    it.side        = s;
    it.edge_weight = w;
    it.edge_cut    = c;
    it.last_pin    = l;
    return it;
  endfunction

  function automatic hfgi_pkg::in_item_t op_item(input logic [1:0] f,
                                                 input logic [hfgi_pkg::VTX_W-1:0] v);
    hfgi_pkg::in_item_t it;
    it             = hfgi_pkg::in_item_t'($urandom);
    it.func        = f;
    it.vertex      = v;
    return it;
  endfunction

  function automatic logic [hfgi_pkg::WGT_W-1:0] pick_weight();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return hfgi_pkg::WGT_W'($urandom);
    endcase
  endfunction

  function automatic logic [hfgi_pkg::VTX_W-1:0] pick_vertex();
    if ($urandom_range(1)) return hot_base + hfgi_pkg::VTX_W'($urandom_range(15));
    return hfgi_pkg::VTX_W'($urandom_range(hfgi_pkg::NUM_VERTICES - 1));
  endfunction

  task automatic add_item(input hfgi_pkg::in_item_t it);
    send_entry_t e;
    e.item     = it;
    e.snd_idle = snd_pct;
    e.rcv_idle = rcv_pct;
    e.drain    = drain_next;
    drain_next = 1'b0;
    items_to_send.push_back(e);
  endtask

  // mostly whole edges with random content, plus reads, noise and rare clears
  task automatic add_random_phase(input int target);
    int         n;
    int         k;
    int         j;
    int         r;
    logic       cut;
    logic       broken;
    logic [hfgi_pkg::WGT_W-1:0] w;
    n = 0;
    hot_base = hfgi_pkg::VTX_W'($urandom);
    while (n < target) begin
      r = $urandom_range(99);
      if (r < 55) begin
        k      = ($urandom_range(9) == 0) ? $urandom_range(16, 6) : $urandom_range(5, 1);
        cut    = 1'($urandom_range(1));
        w      = pick_weight();
        broken = ($urandom_range(9) == 0);
        for (j = 0; j < k; j++) begin
          if (broken) begin
            cut = 1'($urandom_range(1));
            w   = pick_weight();
          end
          add_item(pin_item(pick_vertex(), 1'($urandom_range(1)), w, cut, j == k - 1));
          if ($urandom_range(19) == 0) begin
            add_item(op_item(hfgi_pkg::FUNC_READ, pick_vertex()));
            n++;
          end
        end
        n += k;
      end else if (r < 90) begin
        add_item(op_item(hfgi_pkg::FUNC_READ, pick_vertex()));
        n++;
      end else if (r < 93) begin
        add_item(op_item(FUNC_SPARE, hfgi_pkg::VTX_W'($urandom)));
      end else if (r < 94) begin
        add_item(op_item(hfgi_pkg::FUNC_CLEAR, hfgi_pkg::VTX_W'($urandom)));
        n++;
      end else begin
        add_item((hfgi_pkg::in_item_t'($urandom) |
                  hfgi_pkg::in_item_t'({hfgi_pkg::FUNC_PIN, 29'd0})) &
                 ~hfgi_pkg::in_item_t'({2'b10, 29'd0}));
        n++;
      end
    end
  endtask

  // beat acceptance and prediction
  always @(posedge clk) begin
    push_taken = 1'b0;
    if (rst_n && in_push && !in_full) begin
      push_taken = 1'b1;
      update_gain_model(in_data);
      void'(items_to_send.pop_front());
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    pop_taken = 1'b0;
    if (rst_n && out_pop && !out_empty) begin
      pop_taken = 1'b1;
      if (expected_reads.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: result beat with none expected, got %0h", $realtime, out_data);
      end else begin
        head_read = expected_reads.pop_front();
        check_field("free_gain", head_read.free_gain, out_data.free_gain);
        check_field("internal_weight", head_read.internal_weight, out_data.internal_weight);
        check_field("on_boundary", 32'(head_read.on_boundary), 32'(out_data.on_boundary));
        check_field("boundary_count", 32'(head_read.boundary_count),
                    32'(out_data.boundary_count));
      end
    end
  end

  // driver: a beat once offered is held until taken
  always @(negedge clk) begin
    if (!rst_n || items_to_send.size() == 0) begin
      in_push <= 1'b0;
    end else if (!(in_push && !push_taken)) begin
      if ((items_to_send[0].drain && expected_reads.size() != 0) ||
          $urandom_range(99) < items_to_send[0].snd_idle) begin
        in_push <= 1'b0;
      end else begin
        in_push <= 1'b1;
        in_data <= items_to_send[0].item;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= $urandom_range(99) >=
                 ((items_to_send.size() != 0) ? int'(items_to_send[0].rcv_idle) : 0);
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (push_taken || pop_taken) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    reset_model();
    snd_pct    = 7'd15;
    rcv_pct    = 7'd85;
    drain_next = 1'b0;
    hot_base   = '0;

    // directed
    add_item(op_item(hfgi_pkg::FUNC_READ, 10'd0));
    add_item(pin_item(10'd1023, 1'b0, 16'hFFFF, 1'b0, 1'b1));
    add_item(pin_item(10'd5, 1'b0, 16'hFFFF, 1'b1, 1'b0));
    add_item(pin_item(10'd6, 1'b1, 16'hFFFF, 1'b1, 1'b1));
    add_item(pin_item(10'd5, 1'b0, 16'd1, 1'b1, 1'b0));
    add_item(pin_item(10'd7, 1'b0, 16'd1, 1'b1, 1'b0));
    add_item(pin_item(10'd8, 1'b1, 16'd1, 1'b1, 1'b1));
    // uncut pins closed by a cut last pin
    add_item(pin_item(10'd9, 1'b1, 16'd100, 1'b0, 1'b0));
    add_item(pin_item(10'd10, 1'b0, 16'd100, 1'b0, 1'b0));
    add_item(pin_item(10'd11, 1'b1, 16'd300, 1'b1, 1'b1));
    // a cut pin closed by an uncut last pin, read in mid-edge
    add_item(pin_item(10'd12, 1'b0, 16'd7, 1'b1, 1'b0));
    add_item(op_item(hfgi_pkg::FUNC_READ, 10'd12));
    add_item(pin_item(10'd13, 1'b1, 16'd0, 1'b0, 1'b1));
    add_item(op_item(FUNC_SPARE, 10'd5));
    add_item(op_item(hfgi_pkg::FUNC_READ, 10'd5));
    add_item(op_item(hfgi_pkg::FUNC_READ, 10'd6));
    add_item(op_item(hfgi_pkg::FUNC_READ, 10'd8));
    add_item(op_item(hfgi_pkg::FUNC_READ, 10'd10));
    add_item(op_item(hfgi_pkg::FUNC_READ, 10'd1023));
    add_item(op_item(hfgi_pkg::FUNC_READ, 10'd13));
    add_item(op_item(hfgi_pkg::FUNC_CLEAR, 10'd0));
    add_item(op_item(hfgi_pkg::FUNC_READ, 10'd5));
    add_item(pin_item(10'd0, 1'b1, 16'hFFFF, 1'b1, 1'b1));
    add_item(op_item(hfgi_pkg::FUNC_READ, 10'd0));

    drain_next = 1'b1;
    add_random_phase(570);

    snd_pct    = 7'd85;
    rcv_pct    = 7'd15;
    drain_next = 1'b1;
    add_random_phase(570);

    snd_pct    = 7'd0;
    rcv_pct    = 7'd0;
    drain_next = 1'b1;
    add_random_phase(570);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_to_send.size() != 0 || expected_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
